/* rtl/motor_soft_start_ramp_controller_defines.svh */
`ifndef MOTOR_SOFT_START_RAMP_CONTROLLER_DEFINES_SVH
`define MOTOR_SOFT_START_RAMP_CONTROLLER_DEFINES_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define MSR_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("msr: implication check failed");

// next-cycle implication
`define MSR_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("msr: next-cycle check failed");

`endif

/* rtl/msr_pkg.sv */
package msr_pkg;

	localparam int CFG_W     = 10;
	localparam int DB_W      = 4;
	localparam int TICK_W    = 8;
	localparam int DUTY_W    = 10;
	localparam int DELAY_W   = 17;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_JUMP      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FLOOR     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_SPEED = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CEILING   = 3'd5;

	localparam logic [DB_W-1:0]   RST_DEBOUNCE  = 4'd5;
	localparam logic [TICK_W-1:0] RST_SAMPLE    = 8'd10;
	localparam logic [CFG_W-1:0]  RST_JUMP      = 10'd100;
	localparam logic [CFG_W-1:0]  RST_FLOOR     = 10'd10;
	localparam logic [CFG_W-1:0]  RST_LOW_SPEED = 10'd10;
	localparam logic [CFG_W-1:0]  RST_CEILING   = 10'd1000;

	localparam logic REQ_SLOW = 1'b0;
	localparam logic REQ_FINE = 1'b1;

	typedef struct packed {
		logic [DB_W-1:0]   debounce_ticks;
		logic [TICK_W-1:0] sample_period;
		logic [CFG_W-1:0]  speed_jump;
		logic [CFG_W-1:0]  ramp_floor;
		logic [CFG_W-1:0]  low_speed_limit;
		logic [CFG_W-1:0]  speed_ceiling;
	} cfg_t;

	typedef struct packed {
		logic take;
		logic div_go;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_done;
	} dp_status_t;

endpackage

/* rtl/msr_regs.sv */
module msr_regs import msr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks  <= RST_DEBOUNCE;
			cfg_q.sample_period   <= RST_SAMPLE;
			cfg_q.speed_jump      <= RST_JUMP;
			cfg_q.ramp_floor      <= RST_FLOOR;
			cfg_q.low_speed_limit <= RST_LOW_SPEED;
			cfg_q.speed_ceiling   <= RST_CEILING;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEBOUNCE:  cfg_q.debounce_ticks  <= cfg_data[DB_W-1:0];
				CFG_SAMPLE:    cfg_q.sample_period   <= cfg_data[TICK_W-1:0];
				CFG_JUMP:      cfg_q.speed_jump      <= cfg_data;
				CFG_FLOOR:     cfg_q.ramp_floor      <= cfg_data;
				CFG_LOW_SPEED: cfg_q.low_speed_limit <= cfg_data;
				CFG_CEILING:   cfg_q.speed_ceiling   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/msr_div.sv */
module msr_div import msr_pkg::*; #(
	parameter int DVD_W = 20,
	parameter int DVS_W = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVD_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             fits;

	// one quotient bit per cycle, dividend shifted out of quo_q as quotient shifts in
	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* rtl/msr_dp.sv */
module msr_dp import msr_pkg::*; #(
	parameter int ADC_BITS = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  ctrl_cmd_t           cmd,
	output dp_status_t          sts,
	input  logic                req_type,
	input  logic                start_raw,
	input  logic                dir_raw,
	input  logic [ADC_BITS-1:0] speed_sample,
	input  logic [ADC_BITS-1:0] ramp_sample,
	output logic [DUTY_W-1:0]   duty,
	output logic                dir_drive,
	output logic                start_level,
	output logic                dir_level
);

	localparam int CMP_W = (ADC_BITS > CFG_W) ? ADC_BITS : CFG_W;
	localparam int DVD_W = CMP_W + ADC_BITS;

	// {level, prev, stable} after one slow tick
	function automatic logic [DB_W+1:0] db_step(
		input logic            raw,
		input logic            level,
		input logic            prev,
		input logic [DB_W-1:0] stable,
		input logic [DB_W-1:0] ticks
	);
		logic [DB_W:0]   c;
		logic [DB_W+1:0] r;
		c = {1'b0, stable} + (DB_W+1)'(1);
		if (raw == prev) begin
			if (c >= {1'b0, ticks}) r = {raw, prev, ticks};
			else r = {level, prev, c[DB_W-1:0]};
		end else begin
			r = {level, raw, {DB_W{1'b0}}};
		end
		return r;
	endfunction

	logic [TICK_W-1:0]   tick_q;
	logic                start_state_q, start_prev_q;
	logic [DB_W-1:0]     start_stable_q;
	logic                dirbtn_state_q, dirbtn_prev_q;
	logic [DB_W-1:0]     dirbtn_stable_q;
	logic [DUTY_W-1:0]   speed_set_q;
	logic [ADC_BITS-1:0] speed_prev_q;
	logic [DELAY_W-1:0]  step_delay_q;
	logic [DELAY_W-1:0]  fine_count_q;
	logic [DUTY_W-1:0]   duty_q;
	logic                dir_out_q;

	logic [DUTY_W-1:0]   duty_out_q;
	logic                dir_drive_out_q, start_out_q, dir_level_out_q;

	logic [DB_W+1:0]     start_nx, dirbtn_nx;
	logic [TICK_W-1:0]   tick_inc;
	logic                sample;
	logic [CMP_W-1:0]    spd, rmp, flr, ramp_c, sp_prev, ceil_c;
	logic                jump, recompute, direct;
	logic [DVD_W-1:0]    quo;
	logic                div_done;
	logic [DELAY_W-1:0]  div_delay;
	logic [DUTY_W-1:0]   speed_set_nx;

	logic                step;
	logic [DUTY_W-1:0]   target;
	logic [DUTY_W-1:0]   duty_nx;

	assign start_nx  = db_step(start_raw, start_state_q, start_prev_q, start_stable_q,
		cfg.debounce_ticks);
	assign dirbtn_nx = db_step(dir_raw, dirbtn_state_q, dirbtn_prev_q, dirbtn_stable_q,
		cfg.debounce_ticks);

	assign tick_inc = tick_q + 1'b1;
	assign sample   = tick_inc >= cfg.sample_period;

	assign spd     = CMP_W'(speed_sample);
	assign rmp     = CMP_W'(ramp_sample);
	assign flr     = CMP_W'(cfg.ramp_floor);
	assign sp_prev = CMP_W'(speed_prev_q);
	assign ceil_c  = CMP_W'(cfg.speed_ceiling);
	assign ramp_c  = (rmp < flr) ? flr : rmp;

	// direction compare uses the level debounced on this same tick
	assign jump      = (spd > sp_prev) && ((spd - sp_prev) > CMP_W'(cfg.speed_jump));
	assign recompute = jump || (dirbtn_nx[DB_W+1] == dir_out_q);
	assign direct    = (spd < CMP_W'(cfg.low_speed_limit)) || (spd == '0);

	// min() never exceeds the ceiling register, so it fits the duty width
	assign speed_set_nx = (spd > ceil_c) ? DUTY_W'(ceil_c) : DUTY_W'(spd);

	assign sts.need_div = (req_type == REQ_SLOW) && sample && recompute && !direct;
	assign sts.div_done = div_done;

	msr_div #(
		.DVD_W(DVD_W),
		.DVS_W(ADC_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_go),
		.dividend ({ramp_c, {ADC_BITS{1'b0}}}),
		.divisor  (speed_sample),
		.done     (div_done),
		.quotient (quo)
	);

	assign div_delay = ((quo >> DELAY_W) != '0) ? {DELAY_W{1'b1}} : quo[DELAY_W-1:0];

	assign step   = fine_count_q >= step_delay_q;
	assign target = ((dirbtn_state_q == dir_out_q) && start_state_q) ? speed_set_q : '0;
	always_comb begin
		if (duty_q > target) duty_nx = duty_q - 1'b1;
		else if (duty_q < target) duty_nx = duty_q + 1'b1;
		else duty_nx = duty_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q          <= '0;
			start_state_q   <= 1'b0;
			start_prev_q    <= 1'b0;
			start_stable_q  <= '0;
			dirbtn_state_q  <= 1'b0;
			dirbtn_prev_q   <= 1'b0;
			dirbtn_stable_q <= '0;
			speed_set_q     <= '0;
			speed_prev_q    <= '0;
			step_delay_q    <= '0;
			fine_count_q    <= '0;
			duty_q          <= '0;
			dir_out_q       <= 1'b0;
		end else begin
			if (cmd.take) begin
				if (req_type == REQ_SLOW) begin
					{start_state_q, start_prev_q, start_stable_q}    <= start_nx;
					{dirbtn_state_q, dirbtn_prev_q, dirbtn_stable_q} <= dirbtn_nx;
					if (sample) begin
						tick_q       <= '0;
						speed_prev_q <= speed_sample;
						speed_set_q  <= speed_set_nx;
						if (recompute && direct) step_delay_q <= DELAY_W'(ramp_c);
					end else begin
						tick_q <= tick_inc;
					end
				end else if (step) begin
					fine_count_q <= '0;
					duty_q       <= duty_nx;
					if (duty_nx == '0) dir_out_q <= dirbtn_state_q;
				end else begin
					fine_count_q <= fine_count_q + 1'b1;
				end
			end
			if (div_done) step_delay_q <= div_delay;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			duty_out_q      <= duty_q;
			dir_drive_out_q <= dir_out_q;
			start_out_q     <= start_state_q;
			dir_level_out_q <= dirbtn_state_q;
		end
	end

	assign duty        = duty_out_q;
	assign dir_drive   = dir_drive_out_q;
	assign start_level = start_out_q;
	assign dir_level   = dir_level_out_q;

endmodule

/* rtl/msr_ctrl.sv */
module msr_ctrl import msr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	input  dp_status_t sts,
	output ctrl_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_PUSH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   take;
	logic   load;

	assign take = in_valid && (state_q == ST_IDLE);
	// result register may be refilled in the cycle it is taken
	assign load = (state_q == ST_PUSH) && (!out_valid_q || !out_stall);

	assign cmd.take     = take;
	assign cmd.div_go   = take && sts.need_div;
	assign cmd.load_out = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (take) state_q <= sts.need_div ? ST_DIV : ST_PUSH;
				end
				ST_DIV: begin
					if (sts.div_done) state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

/* rtl/motor_soft_start_ramp_controller.sv */
// Soft-start ramp controller for a DC motor PWM stage. Each request is either a slow tick
// (debounces start/direction pins, and every sample_period ticks latches the speed and ramp
// ADC samples) or a fine tick (advances the step timer, or once it expires restarts it and
// moves duty one count toward its target). Every request yields exactly one result carrying
// the state after it. A request is taken in idle, then waits in the push state until the
// output register is free; a sampling slow tick needing a new step delay first runs the
// bit-serial divider. A new request is taken while the previous result still sits in the
// output register. The user must write configuration only while idle; it is not enforced.
`include "motor_soft_start_ramp_controller_defines.svh"

module motor_soft_start_ramp_controller import msr_pkg::*; #(
	parameter int ADC_BITS = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 req_type,
	input  logic                 start_raw,
	input  logic                 dir_raw,
	input  logic [ADC_BITS-1:0]  speed_sample,
	input  logic [ADC_BITS-1:0]  ramp_sample,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [DUTY_W-1:0]    duty,
	output logic                 dir_drive,
	output logic                 start_level,
	output logic                 dir_level
);

	cfg_t       cfg;
	ctrl_cmd_t  cmd;
	dp_status_t sts;

	msr_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	msr_dp #(
		.ADC_BITS(ADC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.sts          (sts),
		.req_type     (req_type),
		.start_raw    (start_raw),
		.dir_raw      (dir_raw),
		.speed_sample (speed_sample),
		.ramp_sample  (ramp_sample),
		.duty         (duty),
		.dir_drive    (dir_drive),
		.start_level  (start_level),
		.dir_level    (dir_level)
	);

	msr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	`MSR_ASSERT_NEXT(a_take_then_busy, cmd.take, in_stall)
	`MSR_ASSERT_IMPL(a_load_slot_free, cmd.load_out, !(out_valid && out_stall))
	`MSR_ASSERT_NEXT(a_load_then_valid, cmd.load_out, out_valid)

endmodule
